FILE: src/a32fv_pkg.sv
// ----------------------------------------------------------------------------
// a32fv_pkg
// Shared constants, types and the modular add used by the Adler-32 unit.
// ----------------------------------------------------------------------------
package a32fv_pkg;

  // Adler-32 modulus, one bit wider than a sum so the raw add fits
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // Message modes, sampled on the first byte of a message
  localparam logic [1:0] MODE_SUM    = 2'd0;
  localparam logic [1:0] MODE_FILL   = 2'd1;
  localparam logic [1:0] MODE_VERIFY = 2'd2;

  // Number of trailer bytes held back in fill and verify modes
  localparam logic [2:0] TRAILER_BYTES = 3'd4;

  // One result of a closed message
  typedef struct packed {
    logic [31:0] checksum;
    logic        match;
    logic        too_short;
  } result_t;

  // Add two residues and reduce once: both inputs stay below the modulus
  function automatic logic [15:0] add_mod(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= ADLER_MOD) begin
      s = s - ADLER_MOD;
    end
    return s[15:0];
  endfunction

endpackage

FILE: src/adler32_checksum_fill_verify_unit.sv
// ----------------------------------------------------------------------------
// adler32_checksum_fill_verify_unit
// Streaming Adler-32 over message bytes with trailer fill and verify modes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one message byte per
//   transaction with mode and last. Mode is taken from the first byte of a
//   message: sum every byte, fill (checksum excludes the final four bytes)
//   or verify (final four bytes compared little-endian with the checksum).
//   Output channel (out_valid/out_ready) carries one result per message,
//   produced by the transaction that has last set.
// Throughput: one byte per cycle unless a last byte waits for the result
//   slot; per byte, each sum takes one modular add between state registers.
// Latency: the result is valid the cycle after the last byte is accepted.
// Stall: the result register holds while out_ready is low. Bytes without
//   last keep flowing; a last byte waits until the result slot frees up
//   (or is emptied in that same cycle).
// Reset: sums return to low 1 / high 0, no message is open, no result is
//   pending.
// ----------------------------------------------------------------------------
module adler32_checksum_fill_verify_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] checksum,
  output logic        match,
  output logic        too_short
);

  a32fv_pkg::result_t res;
  logic               in_accept;
  logic               slot_free;

  // Accept unless a closing byte would overrun a held result
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = slot_free || !last;
  assign in_accept = in_valid && in_ready;

  a32fv_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (in_accept),
    .mode      (mode),
    .data_byte (data_byte),
    .last      (last),
    .res       (res)
  );

  // Track result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the result of a closing byte
  always_ff @(posedge clk) begin
    if (in_accept && last) begin
      checksum  <= res.checksum;
      match     <= res.match;
      too_short <= res.too_short;
    end
  end

  // A short message never reports a match
  a_short_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(match && too_short))
    else $error("too_short and match both set");

  // A closing byte is taken only when the result slot can be filled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last) |-> slot_free)
    else $error("result overrun");

  // A stalled result is not replaced
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(checksum) && $stable(match)))
    else $error("stalled result changed");

  // No result comes out of reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

FILE: src/a32fv_core.sv
// ----------------------------------------------------------------------------
// a32fv_core
// Running sums, trailer window and message state; computes one byte per step.
// ----------------------------------------------------------------------------
module a32fv_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [1:0]          mode,
  input  logic [7:0]          data_byte,
  input  logic                last,
  output a32fv_pkg::result_t  res
);

  logic [15:0] low_sum, low_sum_next;
  logic [15:0] high_sum, high_sum_next;
  logic [7:0]  window [4];
  logic [7:0]  window_next [4];
  logic [2:0]  window_fill, window_fill_next;
  logic [1:0]  held_mode;
  logic        in_message;

  logic [1:0]  eff_mode;
  logic        trailer_mode;
  logic        window_full;
  logic        add_en;
  logic [7:0]  add_val;
  logic [31:0] trailer;

  // Pick the mode of this message and what enters the sums
  always_comb begin
    eff_mode     = in_message ? held_mode : mode;
    trailer_mode = (eff_mode == a32fv_pkg::MODE_FILL) ||
                   (eff_mode == a32fv_pkg::MODE_VERIFY);
    window_full  = (window_fill >= a32fv_pkg::TRAILER_BYTES);
    add_en       = !trailer_mode || window_full;
    add_val      = trailer_mode ? window[0] : data_byte;
  end

  // Advance sums and window for the byte at hand
  always_comb begin
    low_sum_next     = low_sum;
    high_sum_next    = high_sum;
    window_fill_next = window_fill;
    for (int i = 0; i < 4; i++) begin
      window_next[i] = window[i];
    end
    if (add_en) begin
      low_sum_next  = a32fv_pkg::add_mod(low_sum, {8'd0, add_val});
      high_sum_next = a32fv_pkg::add_mod(high_sum, low_sum_next);
    end
    if (trailer_mode) begin
      if (window_full) begin
        window_next[0] = window[1];
        window_next[1] = window[2];
        window_next[2] = window[3];
        window_next[3] = data_byte;
      end else begin
        window_next[window_fill[1:0]] = data_byte;
        window_fill_next = window_fill + 3'd1;
      end
    end
  end

  // Form the result as seen after this byte
  always_comb begin
    trailer = {window_next[3], window_next[2], window_next[1], window_next[0]};
    res.checksum  = {high_sum_next, low_sum_next};
    res.too_short = trailer_mode && (window_fill_next < a32fv_pkg::TRAILER_BYTES);
    res.match     = (eff_mode == a32fv_pkg::MODE_VERIFY) &&
                    (window_fill_next >= a32fv_pkg::TRAILER_BYTES) &&
                    (trailer == res.checksum);
  end

  // Hold message state; drop back to the start on the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      low_sum     <= 16'd1;
      high_sum    <= 16'd0;
      window_fill <= 3'd0;
      held_mode   <= a32fv_pkg::MODE_SUM;
      in_message  <= 1'b0;
    end else if (step) begin
      if (last) begin
        low_sum     <= 16'd1;
        high_sum    <= 16'd0;
        window_fill <= 3'd0;
        held_mode   <= a32fv_pkg::MODE_SUM;
        in_message  <= 1'b0;
      end else begin
        low_sum     <= low_sum_next;
        high_sum    <= high_sum_next;
        window_fill <= window_fill_next;
        held_mode   <= eff_mode;
        in_message  <= 1'b1;
      end
    end
  end

  // Window bytes are payload: only entries already filled are ever read
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 4; i++) begin
        window[i] <= window_next[i];
      end
    end
  end

endmodule
